/* rtl/cbd_pkg.sv */
// ----------------------------------------------------------------------------
// cbd_pkg: shared types and constants of the chunked body decoder
// Result kinds, character class record and default size width.
// ----------------------------------------------------------------------------
`default_nettype none

package cbd_pkg;

	// Default width of the chunk size accumulator.
	localparam int SIZE_BITS_DEFAULT = 32;

	typedef logic [2:0] kind_t;

	// Result kinds reported for every byte.
	localparam kind_t KIND_FRAME = 3'd0;
	localparam kind_t KIND_DATA  = 3'd1;
	localparam kind_t KIND_END   = 3'd2;
	localparam kind_t KIND_OVF   = 3'd3;
	localparam kind_t KIND_IGN   = 3'd4;

	// Framing characters.
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;

	// Classification of one byte, handed from the classifier to the framer.
	typedef struct packed {
		logic       is_hex;
		logic [3:0] hex_val;
		logic       is_blank;
		logic       is_cr;
		logic       is_lf;
	} char_class_t;

endpackage

`default_nettype wire

/* rtl/cbd_in_if.sv */
// ----------------------------------------------------------------------------
// cbd_in_if: coded byte channel
// Valid/ready channel carrying one raw body byte and its restart mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       first;

	modport source (output valid, output in_byte, output first, input ready);
	modport sink (input valid, input in_byte, input first, output ready);
endinterface

`default_nettype wire

/* rtl/cbd_out_if.sv */
// ----------------------------------------------------------------------------
// cbd_out_if: decoded result channel
// Valid/ready channel carrying one decoded byte and its result kind.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [2:0] kind;

	modport source (output valid, output out_byte, output kind, input ready);
	modport sink (input valid, input out_byte, input kind, output ready);
endinterface

`default_nettype wire

/* rtl/cbd_classify.sv */
// ----------------------------------------------------------------------------
// cbd_classify: byte classifier
// Decodes a byte into hex digit value and framing character flags.
// ----------------------------------------------------------------------------
`default_nettype none

module cbd_classify (
	input  wire logic [7:0]          ch,
	output cbd_pkg::char_class_t     cls
);
	import cbd_pkg::*;

	always_comb begin
		cls = '0;
		if (ch >= 8'h30 && ch <= 8'h39) begin
			cls.is_hex  = 1'b1;
			cls.hex_val = ch[3:0];
		end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
			// Letters a-f and A-F share their low three bits: 1..6 maps to 10..15.
			cls.is_hex  = 1'b1;
			cls.hex_val = 4'd9 + {1'b0, ch[2:0]};
		end
		cls.is_blank = (ch == CHAR_SPACE) || (ch == CHAR_TAB);
		cls.is_cr    = (ch == CHAR_CR);
		cls.is_lf    = (ch == CHAR_LF);
	end

endmodule

`default_nettype wire

/* rtl/cbd_framer.sv */
// ----------------------------------------------------------------------------
// cbd_framer: chunk framing state machine
// Tracks the position in the chunk framing and the size counter, and
// computes the result of the byte in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module cbd_framer #(
	parameter int SIZE_BITS = cbd_pkg::SIZE_BITS_DEFAULT
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 advance,
	input  wire logic [7:0]           ch,
	input  wire logic                 first,
	input  wire cbd_pkg::char_class_t cls,
	output cbd_pkg::kind_t            kind,
	output logic [7:0]                data
);
	import cbd_pkg::*;

	localparam logic [2:0] PH_LEAD   = 3'd0;
	localparam logic [2:0] PH_DIGITS = 3'd1;
	localparam logic [2:0] PH_EXT    = 3'd2;
	localparam logic [2:0] PH_CR     = 3'd3;
	localparam logic [2:0] PH_DATA   = 3'd4;
	localparam logic [2:0] PH_TRL1   = 3'd5;
	localparam logic [2:0] PH_TRL2   = 3'd6;
	localparam logic [2:0] PH_DONE   = 3'd7;

	logic [2:0]           phase_q;
	logic [SIZE_BITS-1:0] remaining_q;
	logic [2:0]           ph;
	logic [SIZE_BITS-1:0] rem;
	logic [2:0]           phase_nxt;
	logic [SIZE_BITS-1:0] rem_nxt;
	logic [SIZE_BITS-1:0] rem_dec;
	logic                 ovf;

	// A byte marked first is decoded from the reset state.
	assign ph      = first ? PH_LEAD : phase_q;
	assign rem     = first ? '0 : remaining_q;
	assign ovf     = rem[SIZE_BITS-1 -: 4] != 4'd0;
	assign rem_dec = rem - {{(SIZE_BITS-1){1'b0}}, 1'b1};

	always_comb begin
		phase_nxt = ph;
		rem_nxt   = rem;
		kind      = KIND_FRAME;
		data      = 8'd0;
		unique case (ph)
			PH_LEAD, PH_DIGITS: begin
				if (ph == PH_LEAD && cls.is_blank) begin
					kind = KIND_FRAME;
				end else if (cls.is_hex) begin
					if (ovf) begin
						phase_nxt = PH_DONE;
						kind      = KIND_OVF;
					end else begin
						rem_nxt   = {rem[SIZE_BITS-5:0], cls.hex_val};
						phase_nxt = PH_DIGITS;
					end
				end else begin
					phase_nxt = cls.is_cr ? PH_CR : PH_EXT;
				end
			end
			PH_EXT: begin
				if (cls.is_cr) begin
					phase_nxt = PH_CR;
				end
			end
			PH_CR: begin
				if (cls.is_lf) begin
					if (rem == '0) begin
						phase_nxt = PH_DONE;
						kind      = KIND_END;
					end else begin
						phase_nxt = PH_DATA;
					end
				end else if (!cls.is_cr) begin
					phase_nxt = PH_EXT;
				end
			end
			PH_DATA: begin
				kind    = KIND_DATA;
				data    = ch;
				rem_nxt = rem_dec;
				if (rem_dec == '0) begin
					phase_nxt = PH_TRL1;
				end
			end
			PH_TRL1: begin
				phase_nxt = PH_TRL2;
			end
			PH_TRL2: begin
				phase_nxt = PH_LEAD;
				rem_nxt   = '0;
			end
			default: begin
				kind = KIND_IGN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LEAD;
			remaining_q <= '0;
		end else if (advance) begin
			phase_q     <= phase_nxt;
			remaining_q <= rem_nxt;
		end
	end

endmodule

`default_nettype wire

/* rtl/chunked_body_decoder.sv */
// ----------------------------------------------------------------------------
// chunked_body_decoder: chunked transfer coding body decoder
// Strips chunk size lines and trailers from a byte stream.
// ----------------------------------------------------------------------------
// Usage: raw body bytes enter on din, one item per byte; set first on the
// byte right after the headers to restart the decoder. Every accepted byte
// gives exactly one item on dout: kind tells whether it was framing, body
// data (out_byte holds the byte), end of body, a size overflow, or a byte
// ignored after the end or overflow. out_byte is zero but for body data.
// The block is a two-register pipeline: an input register feeds the
// classifier and framing state machine, whose result lands in an output
// register. An accepted byte is first held in the input register and its
// result then in the output register; one byte is taken every cycle
// while dout is ready. If the receiver stalls, the output register holds
// its item and the input register still takes one more byte; din.ready
// drops only when both are full. The framing state advances only when a
// byte moves from the input to the output register. Reset empties both
// registers and returns the framer to the start of a size line with a
// zero size counter.
// ----------------------------------------------------------------------------
`default_nettype none

module chunked_body_decoder #(
	parameter int SIZE_BITS = cbd_pkg::SIZE_BITS_DEFAULT
) (
	input wire logic clk,
	input wire logic arst_n,
	cbd_in_if.sink   din,
	cbd_out_if.source dout
);
	import cbd_pkg::*;

	// Input register.
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        first_s1;

	// Output register.
	logic        valid_s2;
	logic [7:0]  out_byte_s2;
	kind_t       kind_s2;

	logic        advance;
	logic        take;
	char_class_t cls;
	kind_t       kind_c;
	logic [7:0]  data_c;

	// The byte in the input register moves on whenever the output register
	// is empty or is being emptied in this cycle.
	assign advance  = valid_s1 && (!valid_s2 || dout.ready);
	assign take     = din.valid && din.ready;
	assign din.ready = !valid_s1 || !valid_s2 || dout.ready;

	cbd_classify u_classify (
		.ch  (byte_s1),
		.cls (cls)
	);

	cbd_framer #(
		.SIZE_BITS (SIZE_BITS)
	) u_framer (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.ch      (byte_s1),
		.first   (first_s1),
		.cls     (cls),
		.kind    (kind_c),
		.data    (data_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1  <= din.in_byte;
			first_s1 <= din.first;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (dout.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_s2 <= data_c;
			kind_s2     <= kind_c;
		end
	end

	assign dout.valid    = valid_s2;
	assign dout.out_byte = out_byte_s2;
	assign dout.kind     = kind_s2;

	// Only body data carries a byte value.
	assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.kind != KIND_DATA |-> dout.out_byte == 8'd0)
		else $error("non-data result carries a byte value");

	// Result kinds stay within the defined set.
	assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid |-> dout.kind <= KIND_IGN)
		else $error("undefined result kind");

	// The pipeline never back-pressures while the receiver is ready.
	assert property (@(posedge clk) disable iff (!arst_n)
		dout.ready |-> din.ready)
		else $error("input stalled with receiver ready");

	// A byte in the input register reaches an empty output register next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !valid_s2 |=> dout.valid)
		else $error("input register did not drain into empty output register");

	// An accepted byte is never dropped from the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("stalled byte lost from input register");

endmodule

`default_nettype wire
